/* rtl/tid_pkg.sv */
package tid_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    localparam int MAX_READ_DEF  = 64;

    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 7;
    localparam int KIND_W    = 2;
    localparam int BUFD_W    = 9;
    localparam int MAPF_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;
    localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CH_NL = 8'd10;
    localparam logic [BYTE_W-1:0] CH_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CH_SP = 8'd32;
    localparam logic [BYTE_W-1:0] ERASE_DEF = 8'd127;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVF  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IS_TERMINAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CANONICAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ERASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_NEWLINE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_CHAR    = 3'd6;

    localparam int MAP_IGNCR = 0;
    localparam int MAP_ICRNL = 1;
    localparam int MAP_INLCR = 2;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_chunk;
        logic [REQ_W-1:0]  request_count;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [BUFD_W-1:0] buffered;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_ERASE,
        CMD_READ
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic              echo;
        logic              canon_chk;
        logic [BYTE_W-1:0] chr;
        logic [REQ_W-1:0]  count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVF,
        ST_ERCHK,
        ST_ER1,
        ST_ER2,
        ST_READ
    } back_state_t;

    typedef struct packed {
        logic      valid;
        logic      from_mem;
        out_item_t item;
    } pend_t;

endpackage

/* rtl/tid_front.sv */
module tid_front #(
    parameter int MAX_READ = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tid_pkg::in_item_t             s_payload,
    input  logic                          cfg_wr_en,
    input  logic [tid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tid_pkg::CFG_DAT_W-1:0] cfg_wdata,
    output logic                          cmd_valid,
    output tid_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);
    import tid_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    logic              is_term_reg;
    logic [MAPF_W-1:0] map_reg;
    logic              canon_reg;
    logic              echo_reg;
    logic              echo_erase_reg;
    logic              echo_nl_reg;
    logic [BYTE_W-1:0] erase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_term_reg    <= 1'b0;
            map_reg        <= 3'd2;
            canon_reg      <= 1'b1;
            echo_reg       <= 1'b1;
            echo_erase_reg <= 1'b1;
            echo_nl_reg    <= 1'b0;
            erase_reg      <= ERASE_DEF;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IS_TERMINAL:  is_term_reg    <= cfg_wdata[0];
                REG_INPUT_MAP:    map_reg        <= cfg_wdata[MAPF_W-1:0];
                REG_CANONICAL:    canon_reg      <= cfg_wdata[0];
                REG_ECHO:         echo_reg       <= cfg_wdata[0];
                REG_ECHO_ERASE:   echo_erase_reg <= cfg_wdata[0];
                REG_ECHO_NEWLINE: echo_nl_reg    <= cfg_wdata[0];
                REG_ERASE_CHAR:   erase_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify the item into one command for the back end
    logic              keep;
    logic [BYTE_W-1:0] c;
    cmd_t              cmd_new;

    always_comb begin
        keep    = 1'b1;
        c       = s_payload.byte_in;
        cmd_new = '{op: CMD_PUSH, echo: 1'b0, canon_chk: 1'b0, chr: '0, count: '0};
        if (s_payload.action == ACT_READ) begin
            cmd_new.op        = CMD_READ;
            cmd_new.canon_chk = is_term_reg & canon_reg;
            cmd_new.count     = (s_payload.request_count > REQ_W'(MAX_READ)) ?
                                REQ_W'(MAX_READ) : s_payload.request_count;
        end else if (!is_term_reg) begin
            cmd_new.chr = c;
        end else begin
            if (c == CH_CR) begin
                if (map_reg[MAP_IGNCR]) begin
                    keep = 1'b0;
                end else if (map_reg[MAP_ICRNL]) begin
                    c = CH_NL;
                end
            end else if (c == CH_NL && map_reg[MAP_INLCR]) begin
                c = CH_CR;
            end
            cmd_new.chr = c;
            if (canon_reg && echo_erase_reg && c == erase_reg) begin
                cmd_new.op   = CMD_ERASE;
                cmd_new.echo = echo_reg;
            end else if (canon_reg) begin
                cmd_new.echo = echo_reg | (echo_nl_reg & (c == CH_NL));
            end else begin
                cmd_new.echo = echo_reg;
            end
        end
    end

    // command queue
    cmd_t             q_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;

    assign s_ready   = cnt_reg < CNT_W'(CMDQ_DEPTH);
    assign push      = s_valid & s_ready & keep;
    assign cmd_valid = cnt_reg != '0;
    assign cmd       = q_mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(CMDQ_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) q_mem[wr_ptr_reg] <= cmd_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (cmd_pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !cmd_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (!push && cmd_pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/tid_back.sv */
module tid_back #(
    parameter int BUF_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    input  tid_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  logic [tid_pkg::OQ_CNT_W-1:0] oq_level,
    output logic                         oq_push,
    output tid_pkg::out_item_t           oq_item
);
    import tid_pkg::*;

    localparam int IDX_W  = $clog2(BUF_DEPTH);
    localparam int FILL_W = $clog2(BUF_DEPTH + 1);

    logic [BYTE_W-1:0] mem [BUF_DEPTH];
    logic [BYTE_W-1:0] q_reg;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next, tail_reg, tail_next, rd_addr;
    logic [FILL_W-1:0] fill_reg, fill_next, nl_reg, nl_next;
    logic [REQ_W-1:0]  cnt_reg, cnt_next;
    pend_t             pend_reg, pend_next;

    logic              wr_en;
    logic              nl_inc, nl_dec;
    logic              full, credit;
    logic [OQ_CNT_W:0] used;
    logic [IDX_W-1:0]  prev_tail;
    logic              rd_last;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(BUF_DEPTH - 1)) return '0;
        return i + 1'b1;
    endfunction

    function automatic logic [BUFD_W-1:0] to_buf(input logic [FILL_W-1:0] v);
        logic [FILL_W+BUFD_W-1:0] w;
        w = {{BUFD_W{1'b0}}, v};
        return w[BUFD_W-1:0];
    endfunction

    function automatic out_item_t mk(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
                                     input logic l, input logic [FILL_W-1:0] f);
        out_item_t r;
        r.kind     = k;
        r.data     = d;
        r.last     = l;
        r.buffered = to_buf(f);
        return r;
    endfunction

    assign prev_tail = (tail_reg == '0) ? IDX_W'(BUF_DEPTH - 1) : tail_reg - 1'b1;
    assign full      = fill_reg == FILL_W'(BUF_DEPTH);
    assign used      = {1'b0, oq_level} + {{OQ_CNT_W{1'b0}}, pend_reg.valid};
    assign credit    = used < (OQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign rd_last   = (REQ_W'(cnt_reg + 1'b1) == cmd.count) || (fill_reg == FILL_W'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) mem[tail_reg] <= cmd.chr;
        q_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        nl_inc     = 1'b0;
        pend_next  = '0;
        rd_addr    = (state_reg == ST_READ) ? head_reg : prev_tail;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && credit) begin
                    unique case (cmd.op)
                        CMD_PUSH: begin
                            if (cmd.echo) begin
                                pend_next.valid = 1'b1;
                                pend_next.item  = mk(KIND_ECHO, cmd.chr, !full, fill_reg);
                            end
                            if (full) begin
                                if (cmd.echo) begin
                                    state_next = ST_OVF;
                                end else begin
                                    pend_next.valid = 1'b1;
                                    pend_next.item  = mk(KIND_OVF, cmd.chr, 1'b1, fill_reg);
                                    cmd_pop         = 1'b1;
                                end
                            end else begin
                                wr_en     = 1'b1;
                                tail_next = idx_inc(tail_reg);
                                fill_next = fill_reg + 1'b1;
                                nl_inc    = cmd.chr == CH_NL;
                                cmd_pop   = 1'b1;
                            end
                        end
                        CMD_ERASE: begin
                            if (fill_reg == '0) cmd_pop = 1'b1;
                            else state_next = ST_ERCHK;
                        end
                        CMD_READ: begin
                            // hold until the previous read's newline count settles
                            if (!(pend_reg.valid && pend_reg.from_mem)) begin
                                if (cmd.count == '0 || fill_reg == '0 ||
                                    (cmd.canon_chk && nl_reg == '0)) begin
                                    pend_next.valid = 1'b1;
                                    pend_next.item  = mk(KIND_NONE, '0, 1'b1, fill_reg);
                                    cmd_pop         = 1'b1;
                                end else begin
                                    cnt_next   = '0;
                                    state_next = ST_READ;
                                end
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_OVF: begin
                if (credit) begin
                    pend_next.valid = 1'b1;
                    pend_next.item  = mk(KIND_OVF, cmd.chr, 1'b1, fill_reg);
                    cmd_pop         = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_ERCHK: begin
                // q_reg holds the byte before the tail
                if (q_reg == CH_NL) begin
                    cmd_pop    = 1'b1;
                    state_next = ST_IDLE;
                end else if (!cmd.echo) begin
                    tail_next  = prev_tail;
                    fill_next  = fill_reg - 1'b1;
                    cmd_pop    = 1'b1;
                    state_next = ST_IDLE;
                end else if (credit) begin
                    tail_next       = prev_tail;
                    fill_next       = fill_reg - 1'b1;
                    pend_next.valid = 1'b1;
                    pend_next.item  = mk(KIND_ECHO, CH_BS, 1'b0, fill_reg - 1'b1);
                    state_next      = ST_ER1;
                end
            end
            ST_ER1: begin
                if (credit) begin
                    pend_next.valid = 1'b1;
                    pend_next.item  = mk(KIND_ECHO, CH_SP, 1'b0, fill_reg);
                    state_next      = ST_ER2;
                end
            end
            ST_ER2: begin
                if (credit) begin
                    pend_next.valid = 1'b1;
                    pend_next.item  = mk(KIND_ECHO, CH_BS, 1'b1, fill_reg);
                    cmd_pop         = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ: begin
                if (credit) begin
                    pend_next.valid    = 1'b1;
                    pend_next.from_mem = 1'b1;
                    pend_next.item     = mk(KIND_DATA, '0, rd_last, fill_reg - 1'b1);
                    head_next          = idx_inc(head_reg);
                    fill_next          = fill_reg - 1'b1;
                    cnt_next           = cnt_reg + 1'b1;
                    if (rd_last) begin
                        cmd_pop    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read data lands in the cycle after its address; patch it in here
    always_comb begin
        oq_push = pend_reg.valid;
        oq_item = pend_reg.item;
        if (pend_reg.from_mem) oq_item.data = q_reg;
        nl_dec  = pend_reg.valid && pend_reg.from_mem && q_reg == CH_NL && nl_reg != '0;
        nl_next = nl_reg;
        if (nl_inc && !nl_dec) nl_next = nl_reg + 1'b1;
        else if (!nl_inc && nl_dec) nl_next = nl_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            nl_reg    <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            nl_reg    <= nl_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* rtl/tid_outq.sv */
module tid_outq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         oq_push,
    input  tid_pkg::out_item_t           oq_item,
    output logic [tid_pkg::OQ_CNT_W-1:0] oq_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tid_pkg::out_item_t           m_payload
);
    import tid_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);

    out_item_t          q_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(OUTQ_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    assign m_valid   = cnt_reg != '0;
    assign m_payload = q_mem[rd_ptr_reg];
    assign pop       = m_valid & m_ready;
    assign oq_level  = cnt_reg;

    always_ff @(posedge aclk) begin
        if (oq_push) q_mem[wr_ptr_reg] <= oq_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (oq_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (oq_push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (!oq_push && pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/tty_input_line_discipline.sv */
// Terminal input line discipline over a byte FIFO of BUF_DEPTH entries. The front end
// applies CR/NL mapping to received bytes and sorts each item into a push, an erase or a
// read command; the back end owns the line buffer memory and carries out one command at a
// time, giving at most one result per cycle. A push that echoes into a full buffer gives
// its echo, then an overflow result. An erase does nothing on an empty buffer; one that
// echoes gives backspace, space, backspace. A read is held while the last byte of a
// previous read is still pending (its newline count settles from the registered memory
// read of that byte). Any cycle that makes a result also waits for room in the result
// queue. A queue of four commands and a four-entry result queue decouple the input and
// result channels. Buffer contents are not cleared at reset; the fill count guards every
// read. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
module tty_input_line_discipline #(
    parameter int BUF_DEPTH = tid_pkg::BUF_DEPTH_DEF,
    parameter int MAX_READ  = tid_pkg::MAX_READ_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tid_pkg::in_item_t             s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tid_pkg::out_item_t            m_payload,
    input  logic                          cfg_wr_en,
    input  logic [tid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tid_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import tid_pkg::*;

    logic                cmd_valid, cmd_pop;
    cmd_t                cmd;
    logic [OQ_CNT_W-1:0] oq_level;
    logic                oq_push;
    out_item_t           oq_item;

    tid_front #(.MAX_READ(MAX_READ)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tid_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .oq_level  (oq_level),
        .oq_push   (oq_push),
        .oq_item   (oq_item)
    );

    tid_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .oq_push   (oq_push),
        .oq_item   (oq_item),
        .oq_level  (oq_level),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* rtl/tid_checker.sv */
module tid_checker #(
    parameter int BUF_DEPTH = tid_pkg::BUF_DEPTH_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tid_pkg::out_item_t m_payload
);
    import tid_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result item changed while stalled");

    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == KIND_NONE |-> m_payload.last && m_payload.data == '0)
        else $error("empty read result not last or carries data");

    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == KIND_OVF |->
            m_payload.last && m_payload.buffered == BUFD_W'(BUF_DEPTH))
        else $error("overflow result with buffer not full");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tty_input_line_discipline tid_checker #(.BUF_DEPTH(BUF_DEPTH)) u_tid_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
